// ===== sv/nsfc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsfc_pkg: shared types and constants of the NMEA sentence framer
// Character codes, phase and kind codes, and the records passed between units.
// ----------------------------------------------------------------------------
package nsfc_pkg;

  localparam int unsigned CntW      = 7;
  localparam int unsigned HdrBytes  = 5;
  localparam int unsigned HdrIdxW   = 3;

  // Longest sentence kept, counting '$' and body bytes up to '\r'
  localparam logic [CntW-1:0] MaxSentenceLen = CntW'(87);

  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChP      = 8'h50;
  localparam logic [7:0] ChQ      = 8'h51;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_BODY = 2'd1,
    PH_TERM = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    KIND_INVALID = 3'd0,
    KIND_PARAM   = 3'd1,
    KIND_ENCAP   = 3'd2,
    KIND_QUERY   = 3'd3,
    KIND_PROP    = 3'd4
  } kind_e;

  // Completed sentence: header bytes 1..5 after '$' and total length
  typedef struct packed {
    logic [HdrBytes-1:0][7:0] hdr;
    logic [CntW-1:0]          len;
  } sent_t;

  // Classified result beat
  typedef struct packed {
    kind_e           kind;
    logic [7:0]      talker_first;
    logic [7:0]      talker_second;
    logic [7:0]      formatter_first;
    logic [7:0]      formatter_second;
    logic [7:0]      formatter_third;
    logic [7:0]      listener_first;
    logic [7:0]      listener_second;
    logic [7:0]      maker_first;
    logic [7:0]      maker_second;
    logic [7:0]      maker_third;
    logic [CntW-1:0] total_length;
  } res_t;

endpackage

// ===== sv/nsfc_framer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsfc_framer: sentence phase tracking and header capture
// Advances the phase, byte count and header bytes on each accepted byte and
// flags a completed sentence on the '\n' after '\r'.
// ----------------------------------------------------------------------------
module nsfc_framer import nsfc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       beat_i,
  input  logic [7:0] rx_byte_i,
  output logic       done_o,
  output sent_t      sent_o
);

  phase_e                   phase_q, phase_d;
  logic [CntW-1:0]          cnt_q, cnt_d;
  logic [HdrBytes-1:0][7:0] hdr_q, hdr_d;
  logic [HdrBytes-1:0][7:0] hdr_cap;
  logic [CntW-1:0]          cnt_inc;
  logic                     in_hdr;
  logic [HdrIdxW-1:0]       hdr_idx;

  assign cnt_inc = cnt_q + CntW'(1);
  assign in_hdr  = (cnt_q >= CntW'(1)) && (cnt_q <= CntW'(HdrBytes));
  assign hdr_idx = HdrIdxW'(cnt_q - CntW'(1));

  always_comb begin
    hdr_cap = hdr_q;
    if (in_hdr) begin
      hdr_cap[hdr_idx] = rx_byte_i;
    end
  end

  // Next phase
  always_comb begin
    phase_d = phase_q;
    if (beat_i) begin
      case (phase_q)
        PH_BODY: begin
          if (rx_byte_i == ChCr) begin
            phase_d = PH_TERM;
          end else if (cnt_inc >= MaxSentenceLen) begin
            phase_d = PH_IDLE;
          end
        end
        PH_TERM: phase_d = PH_IDLE;
        default: phase_d = (rx_byte_i == ChDollar) ? PH_BODY : PH_IDLE;
      endcase
    end
  end

  // Count, header and completion
  always_comb begin
    cnt_d  = cnt_q;
    hdr_d  = hdr_q;
    done_o = 1'b0;
    if (beat_i) begin
      case (phase_q)
        PH_BODY: begin
          hdr_d = hdr_cap;
          if (rx_byte_i != ChCr && cnt_inc >= MaxSentenceLen) begin
            cnt_d = '0;
          end else begin
            cnt_d = cnt_inc;
          end
        end
        PH_TERM: begin
          cnt_d = '0;
          if (rx_byte_i == ChLf) begin
            hdr_d  = hdr_cap;
            done_o = 1'b1;
          end
        end
        default: begin
          if (rx_byte_i == ChDollar) begin
            hdr_d = '0;
            cnt_d = CntW'(1);
          end
        end
      endcase
    end
  end

  assign sent_o.hdr = hdr_cap;
  assign sent_o.len = cnt_inc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
      hdr_q   <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      hdr_q   <= hdr_d;
    end
  end

endmodule

// ===== sv/nsfc_classify.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsfc_classify: sentence classification and result register
// Sorts a completed sentence into parametric, query or proprietary and holds
// the result in an output register backed by a skid stage.
// ----------------------------------------------------------------------------
module nsfc_classify import nsfc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  done_i,
  input  sent_t sent_i,
  input  logic  out_stall_i,
  output logic  out_valid_o,
  output logic  skid_full_o,
  output res_t  res_o
);

  res_t res_c;
  res_t out_q, skid_q;
  logic out_vld_q, skid_vld_q;

  always_comb begin
    res_c              = '0;
    res_c.total_length = sent_i.len;
    if (sent_i.hdr[0] == ChP) begin
      res_c.kind         = KIND_PROP;
      res_c.maker_first  = sent_i.hdr[1];
      res_c.maker_second = sent_i.hdr[2];
      res_c.maker_third  = sent_i.hdr[3];
    end else if (sent_i.hdr[4] == ChQ) begin
      res_c.kind            = KIND_QUERY;
      res_c.talker_first    = sent_i.hdr[0];
      res_c.talker_second   = sent_i.hdr[1];
      res_c.listener_first  = sent_i.hdr[2];
      res_c.listener_second = sent_i.hdr[3];
    end else begin
      res_c.kind             = KIND_PARAM;
      res_c.talker_first     = sent_i.hdr[0];
      res_c.talker_second    = sent_i.hdr[1];
      res_c.formatter_first  = sent_i.hdr[2];
      res_c.formatter_second = sent_i.hdr[3];
      res_c.formatter_third  = sent_i.hdr[4];
    end
  end

  logic out_free;
  assign out_free = !out_vld_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (out_free) begin
        out_vld_q  <= skid_vld_q || done_i;
        skid_vld_q <= 1'b0;
      end else if (done_i) begin
        skid_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_vld_q ? skid_q : res_c;
    end else if (done_i) begin
      skid_q <= res_c;
    end
  end

  assign out_valid_o = out_vld_q;
  assign skid_full_o = skid_vld_q;
  assign res_o       = out_q;

endmodule

// ===== sv/nmea_sentence_framer_classifier.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmea_sentence_framer_classifier: NMEA 0183 sentence framer and classifier
// Frames '$'...'\r\n' sentences from a byte stream and reports each one's
// kind, address characters and length.
// ----------------------------------------------------------------------------
// One received byte is taken per cycle. A sentence opens on '$', its body is
// counted, and it must close with '\r' followed at once by '\n'; a sentence
// that reaches 87 bytes without '\r', or whose '\r' is not followed by '\n',
// is dropped silently (the offending byte too). For each good sentence one
// result beat goes into the output register when the '\n' is taken, or into
// the skid entry while the sink holds the previous one: kind 4 proprietary
// ('P' right after '$', maker code from the next three bytes), kind 3 query
// ('Q' as the fifth header byte, talker and listener), else kind 1 parametric
// (talker and formatter). Fields not used by the kind read 0, as do header
// bytes that a short sentence never delivered. total_length counts '$', '\r'
// and '\n'. The rate is one byte per cycle; results sit in an output register
// with a one-entry skid behind it, so rx_byte is stalled only while both hold
// a result the sink has not taken.
// ----------------------------------------------------------------------------
module nmea_sentence_framer_classifier import nsfc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] kind_o,
  output logic [7:0] talker_first_o,
  output logic [7:0] talker_second_o,
  output logic [7:0] formatter_first_o,
  output logic [7:0] formatter_second_o,
  output logic [7:0] formatter_third_o,
  output logic [7:0] listener_first_o,
  output logic [7:0] listener_second_o,
  output logic [7:0] maker_first_o,
  output logic [7:0] maker_second_o,
  output logic [7:0] maker_third_o,
  output logic [6:0] total_length_o
);

  logic  beat;
  logic  done;
  logic  skid_full;
  sent_t sent;
  res_t  res;

  // Hold off input only while the skid entry is occupied
  assign in_stall_o = skid_full;
  assign beat       = in_valid_i && !in_stall_o;

  nsfc_framer u_framer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .beat_i    (beat),
    .rx_byte_i (rx_byte_i),
    .done_o    (done),
    .sent_o    (sent)
  );

  nsfc_classify u_classify (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .done_i      (done),
    .sent_i      (sent),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .skid_full_o (skid_full),
    .res_o       (res)
  );

  assign kind_o             = res.kind;
  assign talker_first_o     = res.talker_first;
  assign talker_second_o    = res.talker_second;
  assign formatter_first_o  = res.formatter_first;
  assign formatter_second_o = res.formatter_second;
  assign formatter_third_o  = res.formatter_third;
  assign listener_first_o   = res.listener_first;
  assign listener_second_o  = res.listener_second;
  assign maker_first_o      = res.maker_first;
  assign maker_second_o     = res.maker_second;
  assign maker_third_o      = res.maker_third;
  assign total_length_o     = res.total_length;

endmodule

// ===== sv/nsfc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsfc_checker: port-level checks of the sentence framer
// Watches the result channel and the input stall over time.
// ----------------------------------------------------------------------------
module nsfc_checker import nsfc_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [2:0] kind_o,
  input logic [7:0] talker_first_o,
  input logic [7:0] formatter_first_o,
  input logic [7:0] listener_first_o,
  input logic [7:0] maker_first_o,
  input logic [6:0] total_length_o
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o)
      && $stable(total_length_o))
    else $error("stalled result beat changed");

  // Only framed kinds come out
  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (kind_o == KIND_PARAM) || (kind_o == KIND_QUERY)
      || (kind_o == KIND_PROP))
    else $error("unexpected sentence kind");

  // Fields outside the kind read zero
  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_PROP |-> talker_first_o == 8'd0
      && formatter_first_o == 8'd0 && listener_first_o == 8'd0)
    else $error("nonzero field in proprietary result");

  a_param_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_PARAM |-> maker_first_o == 8'd0
      && listener_first_o == 8'd0 && total_length_o >= 7'd3)
    else $error("bad parametric result");

  // Input stall rises only behind a stalled full output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("input stalled without output back-pressure");

endmodule

bind nmea_sentence_framer_classifier nsfc_checker u_nsfc_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_stall_o        (in_stall_o),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .kind_o            (kind_o),
  .talker_first_o    (talker_first_o),
  .formatter_first_o (formatter_first_o),
  .listener_first_o  (listener_first_o),
  .maker_first_o     (maker_first_o),
  .total_length_o    (total_length_o)
);

// ===== sim/tb_nmea_sentence_framer_classifier.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nmea_sentence_framer_classifier: self-checking bench for the NMEA framer
// Feeds byte streams through the valid/stall input and checks every result
// beat against a behavioral framer kept in the bench or, for some table
// rows, typed-in results. A short table of hand-picked sentences is followed
// by random well-formed, broken and noisy sentences. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_nmea_sentence_framer_classifier import nsfc_pkg::*; ();

  // Generous ceiling for roughly 800 bytes with idles and stalls
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned RandomBytes = 400;

  // How a row of the directed table is checked
  typedef enum int {
    ROW_PREDICT,  // expectation comes from the bench framer
    ROW_TYPED,    // expectation is written out in the table
    ROW_NONE      // the row must produce no beat at all
  } row_mode_e;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic [7:0] rx_byte   = 8'h00;
  logic       out_stall = 1'b0;

  logic       in_stall_o;
  logic       out_valid_o;
  logic [2:0] kind_o;
  logic [7:0] talker_first_o;
  logic [7:0] talker_second_o;
  logic [7:0] formatter_first_o;
  logic [7:0] formatter_second_o;
  logic [7:0] formatter_third_o;
  logic [7:0] listener_first_o;
  logic [7:0] listener_second_o;
  logic [7:0] maker_first_o;
  logic [7:0] maker_second_o;
  logic [7:0] maker_third_o;
  logic [6:0] total_length_o;

  // Bench copy of the framer state
  phase_e                   fr_phase = PH_IDLE;
  logic [CntW-1:0]          fr_count = '0;
  logic [HdrBytes-1:0][7:0] fr_hdr   = '0;

  // Sentences that the block still owes us, oldest first
  res_t due_sentences[$];

  // Directed table, kept as parallel queues
  string     plan_text[$];
  row_mode_e plan_mode[$];
  res_t      plan_res[$];

  int unsigned fail_count = 0;
  int unsigned sent_count = 0;
  int unsigned cycles     = 0;
  int          stall_left = 0;
  bit          no_idle    = 1'b0;

  always #1 clk = ~clk;

  nmea_sentence_framer_classifier dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall_o),
    .rx_byte_i         (rx_byte),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall),
    .kind_o            (kind_o),
    .talker_first_o    (talker_first_o),
    .talker_second_o   (talker_second_o),
    .formatter_first_o (formatter_first_o),
    .formatter_second_o(formatter_second_o),
    .formatter_third_o (formatter_third_o),
    .listener_first_o  (listener_first_o),
    .listener_second_o (listener_second_o),
    .maker_first_o     (maker_first_o),
    .maker_second_o    (maker_second_o),
    .maker_third_o     (maker_third_o),
    .total_length_o    (total_length_o)
  );

  // --------------------------------------------------------------------------
  // Bench framer
  // --------------------------------------------------------------------------

  // Capture a byte into the header if it sits at positions 1..5, then advance
  // the count; the count wraps at 7 bits like the hardware.
  function automatic void store_byte(input logic [7:0] b);
    if (fr_count >= 1 && fr_count <= HdrBytes) begin
      fr_hdr[HdrIdxW'(fr_count - CntW'(1))] = b;
    end
    fr_count = fr_count + 1'b1;
  endfunction

  // Sort the captured header into a result: 'P' first wins, then 'Q' as the
  // fifth byte, and everything else is parametric.
  function automatic res_t classify_header();
    res_t r;
    r = '0;
    if (fr_hdr[0] == ChP) begin
      r.kind         = KIND_PROP;
      r.maker_first  = fr_hdr[1];
      r.maker_second = fr_hdr[2];
      r.maker_third  = fr_hdr[3];
    end else if (fr_hdr[4] == ChQ) begin
      r.kind            = KIND_QUERY;
      r.talker_first    = fr_hdr[0];
      r.talker_second   = fr_hdr[1];
      r.listener_first  = fr_hdr[2];
      r.listener_second = fr_hdr[3];
    end else begin
      r.kind             = KIND_PARAM;
      r.talker_first     = fr_hdr[0];
      r.talker_second    = fr_hdr[1];
      r.formatter_first  = fr_hdr[2];
      r.formatter_second = fr_hdr[3];
      r.formatter_third  = fr_hdr[4];
    end
    r.total_length = fr_count;
    return r;
  endfunction

  // Advance the framer by one byte; return 1 with the sentence when a '\n'
  // closes a good sentence.
  function automatic bit frame_byte(input logic [7:0] b, output res_t r);
    bit done;
    done = 1'b0;
    r    = '0;
    case (fr_phase)
      PH_BODY: begin
        store_byte(b);
        if (b == ChCr) begin
          fr_phase = PH_TERM;
        end else if (fr_count >= MaxSentenceLen) begin
          // too long without '\r': drop it
          fr_count = '0;
          fr_phase = PH_IDLE;
        end
      end
      PH_TERM: begin
        // anything but '\n' kills the sentence and is itself swallowed
        if (b == ChLf) begin
          store_byte(b);
          r    = classify_header();
          done = 1'b1;
        end
        fr_count = '0;
        fr_phase = PH_IDLE;
      end
      default: begin
        fr_phase = PH_IDLE;
        if (b == ChDollar) begin
          fr_hdr   = '0;
          fr_count = 7'd1;
          fr_phase = PH_BODY;
        end
      end
    endcase
    return done;
  endfunction

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------

  function automatic int idle_draw();
    return no_idle ? 0 : int'($urandom_range(0, 5));
  endfunction

  // Idle for a drawn number of cycles, present the byte, hold it until the
  // beat is taken, then run it through the bench framer.
  task automatic send_byte(input logic [7:0] b, output bit got, output res_t r);
    int gap;
    gap = idle_draw();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (in_stall_o);
    got = frame_byte(b, r);
    sent_count++;
    // Switch between idling and back-to-back stretches now and then
    if (sent_count % 64 == 0) begin
      no_idle = ($urandom_range(0, 3) == 0);
    end
  endtask

  task automatic add_row(input string text, input row_mode_e mode, input res_t r);
    plan_text.push_back(text);
    plan_mode.push_back(mode);
    plan_res.push_back(r);
  endtask

  // Pick a body byte: mostly printable, sometimes any value or an extreme
  function automatic logic [7:0] body_byte();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      2, 3, 4: return 8'($urandom_range(0, 255));
      default: return 8'($urandom_range(8'h20, 8'h7E));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Output side
  // --------------------------------------------------------------------------

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] seen);
    if (seen !== want) begin
      $error("%s: expected 0x%02h, got 0x%02h", name, want, seen);
      fail_count++;
    end
  endtask

  task automatic check_beat();
    res_t want;
    if (due_sentences.size() == 0) begin
      $error("result beat with no sentence outstanding (kind %0d, length %0d)",
             kind_o, total_length_o);
      fail_count++;
      return;
    end
    want = due_sentences.pop_front();
    check_field("kind",             8'(want.kind),        8'(kind_o));
    check_field("talker_first",     want.talker_first,     talker_first_o);
    check_field("talker_second",    want.talker_second,    talker_second_o);
    check_field("formatter_first",  want.formatter_first,  formatter_first_o);
    check_field("formatter_second", want.formatter_second, formatter_second_o);
    check_field("formatter_third",  want.formatter_third,  formatter_third_o);
    check_field("listener_first",   want.listener_first,   listener_first_o);
    check_field("listener_second",  want.listener_second,  listener_second_o);
    check_field("maker_first",      want.maker_first,      maker_first_o);
    check_field("maker_second",     want.maker_second,     maker_second_o);
    check_field("maker_third",      want.maker_third,      maker_third_o);
    check_field("total_length",     8'(want.total_length), 8'(total_length_o));
  endtask

  // Take result beats; after each one hold off the sink for a drawn number
  // of cycles so back-pressure lands on every phase of the framer.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid_o && !out_stall) begin
        check_beat();
        stall_left = idle_draw();
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left > 0);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    string            longest;
    string            too_long;
    string            text;
    row_mode_e        mode;
    res_t             r;
    bit               got;
    int               i;
    int               j;
    int               n;
    int               pick;
    int unsigned      rand_sent;
    logic [7:0]       line_bytes[$];

    // Longest sentence kept: '$', 85 body bytes, '\r', '\n' gives 88.
    // One more body byte reaches 87 before '\r' and is dropped.
    longest  = "$";
    repeat (85) longest = {longest, "A"};
    too_long = {longest, "A", "\r\n"};
    longest  = {longest, "\r\n"};

    // Plain parametric, proprietary and query sentences
    add_row("$GPGGA,1\r\n", ROW_TYPED,
            {KIND_PARAM, "G", "P", "G", "G", "A", 40'h0, 7'd10});
    add_row("$PGRMZ\r\n", ROW_TYPED,
            {KIND_PROP, 56'h0, "G", "R", "M", 7'd8});
    add_row("$CCGPQ\r\n", ROW_TYPED,
            {KIND_QUERY, "C", "C", 24'h0, "G", "P", 24'h0, 7'd8});
    // Shortest sentence: '\r' and '\n' land in the header as they are
    add_row("$\r\n", ROW_TYPED,
            {KIND_PARAM, 8'h0D, 8'h0A, 64'h0, 7'd3});
    add_row("$P\r\n", ROW_TYPED,
            {KIND_PROP, 56'h0, 8'h0D, 8'h0A, 8'h00, 7'd4});
    // A '$' inside the body is just another byte
    add_row("$ABC$DE\r\n", ROW_TYPED,
            {KIND_PARAM, "A", "B", "C", "$", "D", 40'h0, 7'd9});
    // All-ones header
    add_row("$\377\377\377\377\377\r\n", ROW_TYPED,
            {KIND_PARAM, 40'hFF_FFFF_FFFF, 40'h0, 7'd8});
    // 'P' first beats 'Q' fifth
    add_row("$PAAAQ\r\n", ROW_TYPED,
            {KIND_PROP, 56'h0, "A", "A", "A", 7'd8});
    add_row(longest, ROW_TYPED,
            {KIND_PARAM, "AAAAA", 40'h0, 7'd88});
    // Broken '\r' follow-up; the '$' after '\r' is swallowed, so the rest
    // of that line is idle noise
    add_row("$GPX\rX", ROW_NONE, '0);
    add_row("$\r$GPGSV\r\n", ROW_NONE, '0);
    add_row(too_long, ROW_NONE, '0);
    add_row("\n\rnoise\r\n", ROW_NONE, '0);
    // Left to the bench framer
    add_row("$GPQ\r\n", ROW_PREDICT, '0);
    add_row("$PX\r\n", ROW_PREDICT, '0);
    add_row("$GPGLL,4916.45,N,12311.12,W*31\r\n", ROW_PREDICT, '0);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the directed table
    for (i = 0; i < plan_text.size(); i++) begin
      text = plan_text[i];
      mode = plan_mode[i];
      for (j = 0; j < text.len(); j++) begin
        send_byte(text[j], got, r);
        if (got && mode == ROW_TYPED) begin
          due_sentences.push_back(plan_res[i]);
        end else if (got && mode == ROW_PREDICT) begin
          due_sentences.push_back(r);
        end
      end
    end

    // Random part: mostly framed sentences with random content, some
    // broken or overlong, some loose noise in between
    rand_sent = 0;
    while (rand_sent < RandomBytes) begin
      line_bytes.delete();
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        repeat ($urandom_range(1, 4)) line_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
        line_bytes.push_back(ChDollar);
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 90) : $urandom_range(0, 12);
        for (j = 0; j < n; j++) begin
          line_bytes.push_back(body_byte());
        end
        // steer the header toward the proprietary and query kinds
        if (pick == 1 && n >= 1) line_bytes[1] = ChP;
        if ((pick == 2 || pick == 3) && n >= 5) line_bytes[5] = ChQ;
        case ($urandom_range(0, 9))
          8: begin
            line_bytes.push_back(ChCr);
            line_bytes.push_back(8'($urandom_range(0, 255)));
          end
          9: ;  // no terminator at all
          default: begin
            line_bytes.push_back(ChCr);
            line_bytes.push_back(ChLf);
          end
        endcase
      end
      for (j = 0; j < line_bytes.size(); j++) begin
        send_byte(line_bytes[j], got, r);
        if (got) due_sentences.push_back(r);
        rand_sent++;
      end
    end
    in_valid <= 1'b0;

    // Drain, then keep the clock running so the output register can show
    // anything stray
    while (due_sentences.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (fail_count == 0 && due_sentences.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/nsfc_pkg.sv
sv/nsfc_framer.sv
sv/nsfc_classify.sv
sv/nmea_sentence_framer_classifier.sv
sv/nsfc_checker.sv
sim/tb_nmea_sentence_framer_classifier.sv
